// ----- sv/bfta_pkg.sv -----
// ----------------------------------------------------------------------------
// bfta_pkg - shared types and constants of the best-fit allocator
// Field widths, status codes, datapath micro-ops and control/status bundles.
// ----------------------------------------------------------------------------
package bfta_pkg;

	// fixed field widths of the streams
	localparam int REQ_W       = 19;
	localparam int ADDR_W      = 18;
	localparam int ST_W        = 2;
	localparam int CFG_W       = 3;
	localparam int NEED_W      = 15;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_ZERO  = 2'd1;
	localparam logic [ST_W-1:0] ST_OOM   = 2'd2;
	localparam logic [ST_W-1:0] ST_DFREE = 2'd3;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT0,
		OP_INIT1,
		OP_INIT2,
		OP_INIT3,
		OP_LOAD,
		OP_WSTART,
		OP_WREAD,
		OP_WEVAL,
		OP_GSENT,
		OP_GRDF,
		OP_GEVAL,
		OP_SPLIT1,
		OP_SPLIT2,
		OP_WHDR,
		OP_WFTR,
		OP_CRDPF,
		OP_CPFEV,
		OP_CRDPH,
		OP_CPHEV,
		OP_CRDN,
		OP_CNEV,
		OP_RES
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic [ST_W-1:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic op_free;
		logic req_zero;
		logic pa_zero;
		logic pa_bad;
		logic p_lt_end;
		logic walk_done;
		logic found;
		logic can_grow;
		logic split_big;
	} dp_stat_t;

endpackage

// ----- sv/bfta_dpath.sv -----
// ----------------------------------------------------------------------------
// bfta_dpath - tag store and arithmetic of the allocator
// Holds the boundary-tag memory, the walk pointer, best-fit tracking, heap
// growth bookkeeping and the result register; driven one micro-op a cycle.
// ----------------------------------------------------------------------------
module bfta_dpath
	import bfta_pkg::*;
#(
	parameter int CHUNK_BYTES = 65536,
	parameter int MAX_CHUNKS  = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   cfg_valid,
	input  logic [CFG_W-1:0]       cfg_data,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [ST_W-1:0]        m_tuser
);

	localparam int HEAP_G  = (MAX_CHUNKS * CHUNK_BYTES) / 32;
	localparam int CHUNK_G = CHUNK_BYTES / 32;
	localparam int GW      = $clog2(HEAP_G) + 1;
	localparam int IW      = $clog2(HEAP_G) + 2;
	localparam int DEPTH   = HEAP_G * 4;
	localparam int TW      = GW + 1;
	localparam int CW      = (GW > NEED_W) ? GW : NEED_W;
	localparam int KW      = $clog2(MAX_CHUNKS + 1);
	localparam int LW      = (KW > CFG_W) ? KW : CFG_W;

	// tag word: {size in granules, allocated}
	logic [TW-1:0] mem [DEPTH];
	logic [TW-1:0] rdata_q;

	logic                op_free_q;
	logic                req_zero_q;
	logic [NEED_W-1:0]   need_q;
	logic [ADDR_W-1:0]   pa_q;
	logic [GW-1:0]       p_q;
	logic [GW-1:0]       best_q;
	logic [GW-1:0]       bsize_q;
	logic                found_q;
	logic [GW-1:0]       end_q;
	logic [KW-1:0]       chunks_q;
	logic [CFG_W-1:0]    limit_q;
	logic [GW-1:0]       hdr_q;
	logic [GW-1:0]       acc_q;
	logic                wbit_q;
	logic [GW-1:0]       prev_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic [ST_W-1:0]     res_st_q;

	logic [GW-1:0]       rd_sz;
	logic                rd_al;
	logic [REQ_W:0]      req_sum;
	logic [NEED_W-1:0]   need_d;
	logic [ADDR_W-6:0]   tgt;
	logic                fit, exact, better, sz_zero, p_eq, p_gt, live;
	logic                we, re;
	logic [IW-1:0]       waddr, raddr;
	logic [TW-1:0]       wdata;

	function automatic logic [IW-1:0] word_of(input logic [GW-1:0] g);
		word_of = {g[GW-2:0], 2'b00};
	endfunction

	assign rd_sz   = rdata_q[TW-1:1];
	assign rd_al   = rdata_q[0];
	assign req_sum = {1'b0, s_tdata[REQ_W-1:0]} + (REQ_W+1)'(15);
	assign need_d  = req_sum[REQ_W:5] + NEED_W'(1);
	assign tgt     = pa_q[ADDR_W-1:5];

	// walk evaluation on the tag just read
	assign sz_zero = (rd_sz == '0);
	assign fit     = !rd_al && (CW'(rd_sz) >= CW'(need_q));
	assign exact   = fit && (CW'(rd_sz) == CW'(need_q));
	assign better  = fit && (exact || !found_q || (rd_sz < bsize_q));
	assign p_eq    = (CW'(p_q) == CW'(tgt));
	assign p_gt    = (CW'(p_q) > CW'(tgt));
	assign live    = !sz_zero && p_eq && rd_al;

	always_comb begin
		stat.op_free   = op_free_q;
		stat.req_zero  = req_zero_q;
		stat.pa_zero   = (pa_q == '0);
		stat.pa_bad    = (pa_q[4:0] != 5'b01000);
		stat.p_lt_end  = (p_q < end_q);
		stat.walk_done = sz_zero || (op_free_q ? (p_eq || p_gt) : exact);
		stat.found     = found_q;
		stat.can_grow  = (LW'(chunks_q) < LW'(limit_q)) && (int'(chunks_q) < MAX_CHUNKS);
		stat.split_big = ((CW+1)'(bsize_q) >= ((CW+1)'(need_q) + (CW+1)'(1)));
	end

	// address and data of the tag store for this micro-op
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = '0;
		case (cmd.op)
			OP_INIT0: begin
				we    = 1'b1;
				waddr = IW'(3);
				wdata = {GW'(0), 1'b1};
			end
			OP_INIT1: begin
				we    = 1'b1;
				waddr = IW'(4);
				wdata = {GW'(CHUNK_G - 2), 1'b0};
			end
			OP_INIT2: begin
				we    = 1'b1;
				waddr = IW'((CHUNK_G - 1) * 4 - 1);
				wdata = {GW'(CHUNK_G - 2), 1'b0};
			end
			OP_INIT3: begin
				we    = 1'b1;
				waddr = IW'((CHUNK_G - 1) * 4);
				wdata = {GW'(0), 1'b1};
			end
			OP_WREAD: begin
				re    = 1'b1;
				raddr = word_of(p_q);
			end
			OP_GSENT: begin
				we    = 1'b1;
				waddr = word_of(end_q + GW'(CHUNK_G));
				wdata = {GW'(0), 1'b1};
			end
			OP_GRDF: begin
				re    = 1'b1;
				raddr = word_of(end_q) - IW'(1);
			end
			OP_WHDR: begin
				we    = 1'b1;
				waddr = word_of(hdr_q);
				wdata = {acc_q, wbit_q};
			end
			OP_WFTR: begin
				we    = 1'b1;
				waddr = word_of(hdr_q + acc_q) - IW'(1);
				wdata = {acc_q, wbit_q};
			end
			OP_CRDPF: begin
				re    = 1'b1;
				raddr = word_of(best_q) - IW'(1);
			end
			OP_CRDPH: begin
				re    = 1'b1;
				raddr = word_of(prev_q);
			end
			OP_CRDN: begin
				re    = 1'b1;
				raddr = word_of(best_q + bsize_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// tag store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// control state: heap extent, limit and fit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			chunks_q <= KW'(1);
			end_q    <= GW'(CHUNK_G - 1);
			limit_q  <= CFG_W'(4);
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			case (cmd.op)
				OP_LOAD, OP_WSTART: begin
					found_q <= 1'b0;
				end
				OP_WEVAL: begin
					if (op_free_q ? live : better) begin
						found_q <= 1'b1;
					end
				end
				OP_GEVAL: begin
					chunks_q <= chunks_q + KW'(1);
					end_q    <= end_q + GW'(CHUNK_G);
				end
				default: begin
					found_q <= found_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				op_free_q  <= s_tuser;
				req_zero_q <= (s_tdata[REQ_W-1:0] == '0);
				need_q     <= need_d;
				pa_q       <= s_tdata[REQ_W+ADDR_W-1:REQ_W];
			end
			OP_WSTART: begin
				p_q <= GW'(1);
			end
			OP_WEVAL: begin
				p_q <= p_q + rd_sz;
				if (op_free_q ? live : better) begin
					best_q  <= p_q;
					bsize_q <= rd_sz;
				end
			end
			OP_GEVAL: begin
				wbit_q <= 1'b0;
				if (!rd_al) begin
					hdr_q <= end_q - rd_sz;
					acc_q <= rd_sz + GW'(CHUNK_G);
				end else begin
					hdr_q <= end_q;
					acc_q <= GW'(CHUNK_G);
				end
			end
			OP_SPLIT1: begin
				hdr_q  <= best_q;
				acc_q  <= stat.split_big ? GW'(need_q) : bsize_q;
				wbit_q <= 1'b1;
			end
			OP_SPLIT2: begin
				hdr_q  <= best_q + GW'(need_q);
				acc_q  <= bsize_q - GW'(need_q);
				wbit_q <= 1'b0;
			end
			OP_CPFEV: begin
				prev_q <= best_q - rd_sz;
			end
			OP_CPHEV: begin
				wbit_q <= 1'b0;
				if (!rd_al) begin
					hdr_q <= prev_q;
					acc_q <= bsize_q + rd_sz;
				end else begin
					hdr_q <= best_q;
					acc_q <= bsize_q;
				end
			end
			OP_CNEV: begin
				if (!rd_al) begin
					acc_q <= acc_q + rd_sz;
				end
			end
			OP_RES: begin
				res_st_q <= cmd.st;
				if (cmd.st == ST_OK && !op_free_q) begin
					res_addr_q <= ADDR_W'({best_q, 5'b01000});
				end else begin
					res_addr_q <= '0;
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign m_tdata = {{(OUT_TDATA_W-ADDR_W){1'b0}}, res_addr_q};
	assign m_tuser = res_st_q;

`ifndef SYNTH
	a_chunks_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(chunks_q) >= 1) && (int'(chunks_q) <= MAX_CHUNKS))
		else $error("chunk count out of range");
	a_end_tracks_chunks: assert property (@(posedge clk) disable iff (!arst_n)
		int'(end_q) == int'(chunks_q) * CHUNK_G - 1)
		else $error("heap end does not match chunk count");
	a_fit_large_enough: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !op_free_q) |-> (CW'(bsize_q) >= CW'(need_q)))
		else $error("chosen block smaller than request");
`endif

endmodule

// ----- sv/bfta_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfta_ctrl - sequencer of the allocator
// Runs start-up tag writes, the heap walk, growth, split and coalesce steps,
// and hands each result to the output register.
// ----------------------------------------------------------------------------
module bfta_ctrl
	import bfta_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [4:0] {
		S_INIT0, S_INIT1, S_INIT2, S_INIT3,
		S_IDLE, S_DISP,
		S_WSTART, S_WCHK, S_WEVAL, S_WEND,
		S_GSENT, S_GRDF, S_GEVAL, S_GHDR, S_GFTR,
		S_SPLIT1, S_SHDR1, S_SFTR1, S_SPLIT2, S_SHDR2, S_SFTR2,
		S_CRDPF, S_CPFEV, S_CRDPH, S_CPHEV, S_CRDN, S_CNEV, S_CHDR, S_CFTR,
		S_RES
	} state_t;

	state_t          state_q, state_d;
	logic [ST_W-1:0] code_q, code_d;
	logic            m_tvalid_q;
	logic            res_load;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	// next state and micro-op
	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		res_load = 1'b0;
		cmd.op   = OP_NONE;
		cmd.st   = code_q;
		case (state_q)
			S_INIT0: begin cmd.op = OP_INIT0; state_d = S_INIT1; end
			S_INIT1: begin cmd.op = OP_INIT1; state_d = S_INIT2; end
			S_INIT2: begin cmd.op = OP_INIT2; state_d = S_INIT3; end
			S_INIT3: begin cmd.op = OP_INIT3; state_d = S_IDLE; end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.op_free) begin
					if (stat.pa_zero) begin
						code_d  = ST_OK;
						state_d = S_RES;
					end else if (stat.pa_bad) begin
						code_d  = ST_DFREE;
						state_d = S_RES;
					end else begin
						state_d = S_WSTART;
					end
				end else if (stat.req_zero) begin
					code_d  = ST_ZERO;
					state_d = S_RES;
				end else begin
					state_d = S_WSTART;
				end
			end
			S_WSTART: begin cmd.op = OP_WSTART; state_d = S_WCHK; end
			S_WCHK: begin
				if (stat.p_lt_end) begin
					cmd.op  = OP_WREAD;
					state_d = S_WEVAL;
				end else begin
					state_d = S_WEND;
				end
			end
			S_WEVAL: begin
				cmd.op  = OP_WEVAL;
				state_d = stat.walk_done ? S_WEND : S_WCHK;
			end
			S_WEND: begin
				if (stat.op_free) begin
					if (stat.found) begin
						state_d = S_CRDPF;
					end else begin
						code_d  = ST_DFREE;
						state_d = S_RES;
					end
				end else if (stat.found) begin
					state_d = S_SPLIT1;
				end else if (stat.can_grow) begin
					state_d = S_GSENT;
				end else begin
					code_d  = ST_OOM;
					state_d = S_RES;
				end
			end
			S_GSENT:  begin cmd.op = OP_GSENT;  state_d = S_GRDF; end
			S_GRDF:   begin cmd.op = OP_GRDF;   state_d = S_GEVAL; end
			S_GEVAL:  begin cmd.op = OP_GEVAL;  state_d = S_GHDR; end
			S_GHDR:   begin cmd.op = OP_WHDR;   state_d = S_GFTR; end
			S_GFTR:   begin cmd.op = OP_WFTR;   state_d = S_WSTART; end
			S_SPLIT1: begin cmd.op = OP_SPLIT1; state_d = S_SHDR1; end
			S_SHDR1:  begin cmd.op = OP_WHDR;   state_d = S_SFTR1; end
			S_SFTR1: begin
				cmd.op = OP_WFTR;
				if (stat.split_big) begin
					state_d = S_SPLIT2;
				end else begin
					code_d  = ST_OK;
					state_d = S_RES;
				end
			end
			S_SPLIT2: begin cmd.op = OP_SPLIT2; state_d = S_SHDR2; end
			S_SHDR2:  begin cmd.op = OP_WHDR;   state_d = S_SFTR2; end
			S_SFTR2: begin
				cmd.op  = OP_WFTR;
				code_d  = ST_OK;
				state_d = S_RES;
			end
			S_CRDPF: begin cmd.op = OP_CRDPF; state_d = S_CPFEV; end
			S_CPFEV: begin cmd.op = OP_CPFEV; state_d = S_CRDPH; end
			S_CRDPH: begin cmd.op = OP_CRDPH; state_d = S_CPHEV; end
			S_CPHEV: begin cmd.op = OP_CPHEV; state_d = S_CRDN; end
			S_CRDN:  begin cmd.op = OP_CRDN;  state_d = S_CNEV; end
			S_CNEV:  begin cmd.op = OP_CNEV;  state_d = S_CHDR; end
			S_CHDR:  begin cmd.op = OP_WHDR;  state_d = S_CFTR; end
			S_CFTR: begin
				cmd.op  = OP_WFTR;
				code_d  = ST_OK;
				state_d = S_RES;
			end
			S_RES: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.op   = OP_RES;
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold state, status code and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT0;
			code_q     <= ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_accept_starts_op: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_DISP))
		else $error("accepted beat did not start an operation");
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RES && m_tvalid_q && !m_tready) |=> (state_q == S_RES && m_tvalid_q))
		else $error("result loaded over an untaken beat");
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> m_tvalid_q)
		else $error("result beat dropped before it was taken");
`endif

endmodule

// ----- sv/best_fit_boundary_tag_allocator_top.sv -----
// ----------------------------------------------------------------------------
// best_fit_boundary_tag_allocator_top - best-fit boundary-tag heap allocator
// Allocate and free requests in, one address/status beat out per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the block writes the start
// sentinel, first free block and end sentinel before it raises s_tready.
// An allocate walks the blocks of the heap through the single tag-store read
// port, stopping early at the end sentinel or at an exact fit, and walks again
// after each chunk the heap grows by; a free walks the blocks up to its target
// and then coalesces. A result waits in the output register while the next
// request is already taken in. Zero-size and null requests skip the walk.
module best_fit_boundary_tag_allocator_top
	import bfta_pkg::*;
#(
	parameter int CHUNK_BYTES = 65536,
	parameter int MAX_CHUNKS  = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // request_bytes[18:0], payload_address[36:19], zero fill
	input  logic                   s_tuser,  // opcode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // result_address[17:0], zero fill
	output logic [ST_W-1:0]        m_tuser,  // status
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data  // chunk_limit
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	bfta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	bfta_dpath #(
		.CHUNK_BYTES (CHUNK_BYTES),
		.MAX_CHUNKS  (MAX_CHUNKS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
